// ----- hw/rtl/bitmap_set_store_unit_macros.svh -----
// ----------------------------------------------------------------------------
// bitmap set store assertion macros
// concurrent checks clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BITMAP_SET_STORE_UNIT_MACROS_SVH
`define BITMAP_SET_STORE_UNIT_MACROS_SVH

// same-cycle implication
`define BSS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bss_pkg.sv -----
// ----------------------------------------------------------------------------
// bss_pkg
// shared types and codes of the bitmap set store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bss_pkg;

    localparam int unsigned IDX_W = 12;
    localparam int unsigned CNT_W = 13;

    // request kinds
    localparam logic [2:0] REQ_INSERT   = 3'd0;
    localparam logic [2:0] REQ_REMOVE   = 3'd1;
    localparam logic [2:0] REQ_CONTAINS = 3'd2;
    localparam logic [2:0] REQ_FIND     = 3'd3;
    localparam logic [2:0] REQ_CLEAR    = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_RANGE       = 2'd1;
    localparam logic [1:0] ST_PRESENT     = 2'd2;
    localparam logic [1:0] ST_NOT_PRESENT = 2'd3;

    localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [IDX_W-1:0] index;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             present;
        logic             found;
        logic [IDX_W-1:0] next_index;
        logic [CNT_W-1:0] member_count;
        logic             is_empty;
        logic             is_full;
    } rsp_t;

endpackage

// ----- hw/rtl/bss_scan_unit.sv -----
// ----------------------------------------------------------------------------
// bss_scan_unit
// lowest set bit of one bitmap word inside a window of bit positions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bss_scan_unit #(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic [WORD_BITS-1:0]         word,
    input  logic [$clog2(WORD_BITS)-1:0] lo,
    input  logic [$clog2(WORD_BITS):0]   lim,
    output logic                         hit,
    output logic [$clog2(WORD_BITS)-1:0] pos
);

    localparam int unsigned BW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] window;
    logic [WORD_BITS-1:0] masked;
    logic [WORD_BITS-1:0] lowest;

    // window keeps positions lo <= b < lim
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            window[b] = ((BW+1)'(b) >= {1'b0, lo}) && ((BW+1)'(b) < lim);
        end
    end

    assign masked = word & window;
    assign lowest = masked & (~masked + WORD_BITS'(1));
    assign hit    = |masked;

    // one-hot to binary, each output bit an or over a fixed pattern
    always_comb
    begin
        for (int k = 0; k < BW; k++)
        begin
            pos[k] = 1'b0;
            for (int b = 0; b < WORD_BITS; b++)
            begin
                if (((b >> k) & 1) == 1)
                begin
                    pos[k] = pos[k] | lowest[b];
                end
            end
        end
    end

endmodule

// ----- hw/rtl/bitmap_set_store_unit.sv -----
// insert, remove, contains: S_QUOT, S_READ, S_EVAL, S_DONE, then the result is registered
// find next: the same, staying in S_EVAL for each further word scanned; other kinds: S_DONE only
// clear: S_CLEAR zeroes one bitmap word per cycle over every word, then S_DONE
// one transaction at a time, the next one taken the cycle after the result
// is registered; a stalled result holds the block busy
// reset: count cleared, capacity back to 4096, then an S_INIT pass of memory clearing
// ----------------------------------------------------------------------------
// bitmap_set_store_unit
// set of indices held as a bitmap in a word memory, with member count,
// insert, remove, contains, find next member and clear
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_set_store_unit_macros.svh"

module bitmap_set_store_unit #(
    parameter int unsigned CAPACITY  = 4096,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  bss_pkg::req_t                in_data,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output bss_pkg::rsp_t                out_data,
    // capacity register write
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bss_pkg::CNT_W-1:0]    cfg_data
);

    localparam int unsigned IDX_W     = bss_pkg::IDX_W;
    localparam int unsigned CNT_W     = bss_pkg::CNT_W;
    localparam int unsigned NUM_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int unsigned BW        = $clog2(WORD_BITS);
    // wide enough for any bit position plus one word
    localparam int unsigned XW        = $clog2(NUM_WORDS * WORD_BITS + WORD_BITS + 1);
    // index to word: multiply by a rounded-up reciprocal, exact for 12-bit indices
    localparam int unsigned SHIFT     = IDX_W + BW;
    localparam int unsigned RECIP     = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned PRW       = 2 * IDX_W + 1;
    localparam logic [CNT_W-1:0] CAP_SAT =
        (CAPACITY > 8191) ? {CNT_W{1'b1}} : CNT_W'(CAPACITY);
    localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_QUOT,
        S_READ,
        S_EVAL,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [2:0]           req_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [PRW-1:0]       prod_reg;
    logic [AW-1:0]        word_reg;
    logic [BW-1:0]        bit_reg;
    logic [XW-1:0]        base_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     cap_cfg_reg;
    logic [1:0]           status_reg;
    logic                 present_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     next_reg;
    logic                 out_valid_reg;
    bss_pkg::rsp_t        out_reg;

    // bitmap memory and its registered read port
    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_reg;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;

    logic [CNT_W-1:0]     cap_eff;
    logic [XW-1:0]        cap_x;
    logic                 idx_in_range;
    logic                 cur_bit;
    logic [WORD_BITS-1:0] flip_word;
    logic [XW-1:0]        span;
    logic [BW:0]          lim;
    logic                 scan_hit;
    logic [BW-1:0]        scan_pos;
    logic                 scan_last;
    logic                 in_accept;
    logic                 out_free;
    logic                 done_fire;

    // effective capacity, register saturated to the storage size
    assign cap_eff      = (cap_cfg_reg > CAP_SAT) ? CAP_SAT : cap_cfg_reg;
    assign cap_x        = XW'(cap_eff);
    assign idx_in_range = {1'b0, idx_reg} < cap_eff;

    assign cur_bit   = rd_reg[bit_reg];
    assign flip_word = rd_reg ^ (WORD_BITS'(1) << bit_reg);

    // valid positions left in the current word; base stays below capacity here
    assign span      = cap_x - base_reg;
    assign lim       = (span >= XW'(WORD_BITS)) ? (BW+1)'(WORD_BITS) : (BW+1)'(span);
    assign scan_last = (base_reg + XW'(WORD_BITS)) >= cap_x;

    bss_scan_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_scan (
        .word (rd_reg),
        .lo   (bit_reg),
        .lim  (lim),
        .hit  (scan_hit),
        .pos  (scan_pos)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign done_fire = (state_reg == S_DONE) && out_free;
    assign cfg_ready = 1'b1;

    // the scan reads one word ahead while staying in evaluate
    assign rd_addr = (state_reg == S_EVAL) ? (word_reg + AW'(1)) : word_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = flip_word;
        unique case (state_reg) inside
            S_INIT, S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            S_EVAL:
            begin
                if (req_reg == bss_pkg::REQ_INSERT)
                begin
                    mem_we = idx_in_range && !cur_bit;
                end
                else if (req_reg == bss_pkg::REQ_REMOVE)
                begin
                    mem_we = idx_in_range && cur_bit;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[word_reg] <= mem_wdata;
        end
        rd_reg <= mem[rd_addr];
    end

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_cfg_reg <= bss_pkg::CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_cfg_reg <= cfg_data;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            word_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // result register drains independently of the sequencer
            if (out_valid_reg && !out_stall && !done_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                // memory clearing pass after reset
                S_INIT:
                begin
                    if (word_reg == LAST_WORD)
                    begin
                        word_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        word_reg <= word_reg + AW'(1);
                    end
                end

                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        req_reg     <= in_data.req_type;
                        idx_reg     <= in_data.index;
                        prod_reg    <= PRW'(in_data.index) * PRW'(RECIP);
                        status_reg  <= bss_pkg::ST_OK;
                        present_reg <= 1'b0;
                        found_reg   <= 1'b0;
                        next_reg    <= '0;
                        word_reg    <= '0;
                        case (in_data.req_type) inside
                            bss_pkg::REQ_INSERT, bss_pkg::REQ_REMOVE,
                            bss_pkg::REQ_CONTAINS, bss_pkg::REQ_FIND:
                                state_reg <= S_QUOT;
                            bss_pkg::REQ_CLEAR:
                                state_reg <= S_CLEAR;
                            default:
                                state_reg <= S_DONE;
                        endcase
                    end
                end

                // word number from the reciprocal product
                S_QUOT:
                begin
                    word_reg  <= AW'(prod_reg >> SHIFT);
                    state_reg <= S_READ;
                end

                // bit within word, word base; memory read issued at word_reg
                S_READ:
                begin
                    bit_reg   <= BW'(idx_reg - IDX_W'(word_reg * WORD_BITS));
                    base_reg  <= XW'(word_reg * WORD_BITS);
                    state_reg <= S_EVAL;
                end

                S_EVAL:
                begin
                    case (req_reg)
                        bss_pkg::REQ_INSERT:
                        begin
                            if (!idx_in_range)
                            begin
                                status_reg <= bss_pkg::ST_RANGE;
                            end
                            else if (cur_bit)
                            begin
                                status_reg <= bss_pkg::ST_PRESENT;
                            end
                            else
                            begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                            state_reg <= S_DONE;
                        end
                        bss_pkg::REQ_REMOVE:
                        begin
                            if (!idx_in_range)
                            begin
                                status_reg <= bss_pkg::ST_RANGE;
                            end
                            else if (!cur_bit)
                            begin
                                status_reg <= bss_pkg::ST_NOT_PRESENT;
                            end
                            else
                            begin
                                count_reg <= count_reg - CNT_W'(1);
                            end
                            state_reg <= S_DONE;
                        end
                        bss_pkg::REQ_CONTAINS:
                        begin
                            present_reg <= idx_in_range && cur_bit;
                            state_reg   <= S_DONE;
                        end
                        default:
                        begin
                            // find next: one word per cycle
                            if (!idx_in_range)
                            begin
                                state_reg <= S_DONE;
                            end
                            else if (scan_hit)
                            begin
                                found_reg <= 1'b1;
                                next_reg  <= IDX_W'(base_reg + XW'(scan_pos));
                                state_reg <= S_DONE;
                            end
                            else if (scan_last)
                            begin
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                word_reg <= word_reg + AW'(1);
                                base_reg <= base_reg + XW'(WORD_BITS);
                                bit_reg  <= '0;
                            end
                        end
                    endcase
                end

                // clear request sweeps every word
                S_CLEAR:
                begin
                    if (word_reg == LAST_WORD)
                    begin
                        count_reg <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        word_reg <= word_reg + AW'(1);
                    end
                end

                // hand the result over once the output register is free
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_reg.status       <= status_reg;
                        out_reg.present      <= present_reg;
                        out_reg.found        <= found_reg;
                        out_reg.next_index   <= next_reg;
                        out_reg.member_count <= count_reg;
                        out_reg.is_empty     <= (count_reg == '0);
                        out_reg.is_full      <= (count_reg == cap_eff);
                        out_valid_reg        <= 1'b1;
                        state_reg            <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // an accepted transaction always leaves idle
    `BSS_ASSERT_NEXT(a_accept_busy, in_accept, state_reg != S_IDLE, "accept did not start work")

    // a finished transaction lands in the output register and frees the block
    `BSS_ASSERT_NEXT(a_done_out, done_fire, out_valid_reg && (state_reg == S_IDLE), "no result")

    // empty flag agrees with the reported count
    `BSS_ASSERT_IMPLY(a_empty_flag, out_valid, out_data.is_empty != |out_data.member_count, "empty flag")

endmodule
